>>> rtl/sse_pkg.sv
package sse_pkg;

  // Default number of cells in the sorting chain.
  localparam int unsigned CAPACITY = 16;

  // Width of one data value.
  localparam int unsigned DATA_W = 32;

  // One input beat.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     is_last;
  } in_beat_t;

  // One output beat.
  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     end_of_batch;
    logic                     overflow;
  } out_beat_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;  // Place the incoming value into the sorted chain.
    logic shift;   // Move every cell one place toward the head.
  } cell_ctrl_t;

endpackage

>>> rtl/sse_cell.sv
module sse_cell (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  sse_pkg::cell_ctrl_t                   ctrl_i,
  input  logic signed [sse_pkg::DATA_W-1:0]     new_value_i,
  input  logic                                  left_take_i,
  input  logic                                  left_valid_i,
  input  logic signed [sse_pkg::DATA_W-1:0]     left_value_i,
  input  logic                                  right_valid_i,
  input  logic signed [sse_pkg::DATA_W-1:0]     right_value_i,
  output logic                                  take_o,
  output logic                                  valid_o,
  output logic signed [sse_pkg::DATA_W-1:0]     value_o
);

  logic                              valid_q, valid_d;
  logic signed [sse_pkg::DATA_W-1:0] value_q, value_d;

  // An empty cell counts as larger than any value, so the take bits along
  // the chain form a single step from zero to one.
  assign take_o = !valid_q || (new_value_i < value_q);

  // On insert, a taking cell gets its left neighbor's entry, or the new
  // value when it is the first taking cell. On shift, every cell gets its right
  // neighbor's entry.
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctrl_i.shift) begin
      valid_d = right_valid_i;
      value_d = right_value_i;
    end else if (ctrl_i.insert && take_o) begin
      if (left_take_i) begin
        valid_d = left_valid_i;
        value_d = left_value_i;
      end else begin
        valid_d = 1'b1;
        value_d = new_value_i;
      end
    end
  end

  // Occupancy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Stored value.
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign valid_o = valid_q;
  assign value_o = value_q;

endmodule

>>> rtl/selection_sort_engine.sv
// Channel | Direction | Handshake                  | Beat
// --------+-----------+----------------------------+------------------------
// in      | input     | in_valid_i / in_stall_o    | sse_pkg::in_beat_t
// out     | output    | out_valid_o / out_stall_i  | sse_pkg::out_beat_t
//
// Each input beat is inserted into the sorted chain of cells in the cycle it
// is accepted, unless the chain is full: then it is dropped and flagged.
// After the last beat, the chain drains one result per cycle from its head
// whenever the output is not stalled.
// The input stalls while a batch drains; the output stall freezes the chain.
// Reset empties every cell and clears the overflow flag; no clearing pass.
module selection_sort_engine #(
  parameter int unsigned CAPACITY = sse_pkg::CAPACITY
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sse_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sse_pkg::out_beat_t out_beat_o
);

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic state_q, state_d;
  logic dropped_q, dropped_d;

  sse_pkg::cell_ctrl_t ctrl;

  logic                              take   [CAPACITY];
  logic                              valid  [CAPACITY];
  logic signed [sse_pkg::DATA_W-1:0] value  [CAPACITY];

  logic in_fire, out_fire, full, final_beat;

  // Handshakes.
  assign in_stall_o  = (state_q == ST_DRAIN);
  assign in_fire     = in_valid_i && (state_q == ST_LOAD);
  assign out_valid_o = (state_q == ST_DRAIN);
  assign out_fire    = out_valid_o && !out_stall_i;

  // The chain is full when its tail cell holds a value.
  assign full       = valid[CAPACITY-1];
  assign final_beat = !valid[1];

  // Chain control.
  assign ctrl.insert = in_fire && !full;
  assign ctrl.shift  = out_fire;

  // Batch sequencing and overflow tracking.
  always_comb begin
    state_d   = state_q;
    dropped_d = dropped_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (full) begin
            dropped_d = 1'b1;
          end
          if (in_beat_i.is_last) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_fire && final_beat) begin
          state_d   = ST_LOAD;
          dropped_d = 1'b0;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      dropped_q <= dropped_d;
    end
  end

  // Row of sorting cells; cell 0 holds the smallest value.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                              l_take, l_valid, r_valid;
    logic signed [sse_pkg::DATA_W-1:0] l_value, r_value;

    if (i == 0) begin : g_head
      assign l_take  = 1'b0;
      assign l_valid = 1'b0;
      assign l_value = '0;
    end else begin : g_mid
      assign l_take  = take[i-1];
      assign l_valid = valid[i-1];
      assign l_value = value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_value = '0;
    end else begin : g_body
      assign r_valid = valid[i+1];
      assign r_value = value[i+1];
    end

    sse_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_value_i   (in_beat_i.value),
      .left_take_i   (l_take),
      .left_valid_i  (l_valid),
      .left_value_i  (l_value),
      .right_valid_i (r_valid),
      .right_value_i (r_value),
      .take_o        (take[i]),
      .valid_o       (valid[i]),
      .value_o       (value[i])
    );
  end

  // The head cell is the output register.
  assign out_beat_o.sorted_value = value[0];
  assign out_beat_o.end_of_batch = final_beat;
  assign out_beat_o.overflow     = dropped_q;

endmodule

>>> tb/selection_sort_engine_checker.sv
module selection_sort_engine_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  sse_pkg::in_beat_t  in_beat_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  sse_pkg::out_beat_t out_beat_i,
  output int unsigned        pending_o,
  output int unsigned        errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Values of the batch being loaded, kept in ascending order as they arrive.
  logic signed [sse_pkg::DATA_W-1:0] ordered_q[$];
  logic                              dropped_any;

  // Sorted beats still owed by the block, oldest first.
  sse_pkg::out_beat_t sorted_q[$];
  int unsigned        mismatch_count;

  // Take one accepted input beat into the batch and, on the last one,
  // queue the whole batch in ascending order.
  task automatic load_value(input sse_pkg::in_beat_t beat);
    int unsigned        pos;
    sse_pkg::out_beat_t res;
    if (ordered_q.size() < sse_pkg::CAPACITY) begin
      pos = 0;
      // Equal values go after the ones already held, so duplicates sit together.
      while (pos < ordered_q.size() && $signed(ordered_q[pos]) <= $signed(beat.value)) begin
        pos++;
      end
      ordered_q.insert(pos, beat.value);
    end else begin
      // Store is full: this value is lost and the batch is flagged.
      dropped_any = 1'b1;
    end
    if (beat.is_last) begin
      foreach (ordered_q[k]) begin
        res.sorted_value = ordered_q[k];
        res.end_of_batch = (k == ordered_q.size() - 1);
        res.overflow     = dropped_any;
        sorted_q.push_back(res);
      end
      ordered_q.delete();
      dropped_any = 1'b0;
    end
  endtask

  // Compare one accepted output beat with the oldest expected one.
  task automatic check_result(input sse_pkg::out_beat_t got);
    sse_pkg::out_beat_t want;
    if (sorted_q.size() == 0) begin
      $display("%0t: unexpected beat, expected none, got value %0d last %0b overflow %0b",
               $time, got.sorted_value, got.end_of_batch, got.overflow);
      mismatch_count++;
    end else begin
      want = sorted_q.pop_front();
      if (got.sorted_value !== want.sorted_value) begin
        $display("%0t: sorted_value expected %0d got %0d",
                 $time, want.sorted_value, got.sorted_value);
        mismatch_count++;
      end
      if (got.end_of_batch !== want.end_of_batch) begin
        $display("%0t: end_of_batch expected %0b got %0b",
                 $time, want.end_of_batch, got.end_of_batch);
        mismatch_count++;
      end
      if (got.overflow !== want.overflow) begin
        $display("%0t: overflow expected %0b got %0b", $time, want.overflow, got.overflow);
        mismatch_count++;
      end
    end
  endtask

  // Output beats are checked before the input side is predicted, since a
  // beat leaving at this edge can never belong to a batch ending at it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ordered_q.delete();
      sorted_q.delete();
      dropped_any    = 1'b0;
      mismatch_count = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        check_result(out_beat_i);
      end
      if (in_valid_i && !in_stall_i) begin
        load_value(in_beat_i);
      end
      pending_o <= sorted_q.size();
      errors_o  <= mismatch_count;
    end
  end

endmodule

>>> tb/selection_sort_engine_tb.sv
module selection_sort_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 200;
  localparam int unsigned LONG_HOLD    = 120;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DW           = sse_pkg::DATA_W;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  sse_pkg::in_beat_t  in_beat   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  sse_pkg::out_beat_t out_beat;

  int unsigned pending_results;
  int unsigned errors;
  int unsigned burst_left  = 0;
  int unsigned sent_items  = 0;
  int unsigned cycle_count = 0;
  bit          hold_req    = 1'b0;

  always #1 clk = ~clk;

  selection_sort_engine dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat)
  );

  selection_sort_engine_checker sort_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_beat_i  (out_beat),
    .pending_o   (pending_results),
    .errors_o    (errors)
  );

  // Offer one beat and hold it until accepted. Unless steady, the sender
  // runs in bursts with random gaps between them.
  task automatic offer(input logic signed [DW-1:0] v, input logic last, input bit steady);
    int unsigned gap;
    if (!steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_beat  <= '{value: v, is_last: last};
    do @(posedge clk); while (in_stall);
    sent_items++;
  endtask

  // Stop offering and wait until every sorted beat owed has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // Mix of extremes, a narrow band that gives many duplicates, and full range.
  function automatic logic signed [DW-1:0] pick_value();
    logic signed [DW-1:0] v;
    case ($urandom_range(5))
      0:       v = $urandom_range(1) ? {1'b0, {(DW-1){1'b1}}} : {1'b1, {(DW-1){1'b0}}};
      1, 2:    v = $urandom_range(16) - 8;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Mostly batches that fit, with full and overflowing ones mixed in.
  function automatic int unsigned pick_length();
    case ($urandom_range(9))
      0:       return sse_pkg::CAPACITY;
      1:       return $urandom_range(sse_pkg::CAPACITY + 1, sse_pkg::CAPACITY + 4);
      2:       return 1;
      default: return $urandom_range(2, sse_pkg::CAPACITY - 1);
    endcase
  endfunction

  task automatic send_batch(input int unsigned len, input bit steady);
    for (int unsigned k = 0; k < len; k++) begin
      offer(pick_value(), k == len - 1, steady);
    end
  endtask

  // Sender: directed batches first, then random batches, then the verdict.
  initial begin : stimulus
    int unsigned batch_idx;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-value batches at both ends of the range.
    offer({1'b1, {(DW-1){1'b0}}}, 1'b1, 1'b0);
    offer({1'b0, {(DW-1){1'b1}}}, 1'b1, 1'b0);
    // Extremes, zero and a duplicated value in one batch.
    offer(0, 1'b0, 1'b0);
    offer(-1, 1'b0, 1'b0);
    offer({1'b0, {(DW-1){1'b1}}}, 1'b0, 1'b0);
    offer({1'b1, {(DW-1){1'b0}}}, 1'b0, 1'b0);
    offer(-1, 1'b0, 1'b0);
    offer(1, 1'b1, 1'b1);
    // A full store in descending order; the last value arrives with no room.
    for (int k = 0; k < sse_pkg::CAPACITY; k++) begin
      offer(8 - k, 1'b0, 1'b0);
    end
    offer({1'b0, {(DW-1){1'b1}}}, 1'b1, 1'b0);
    wait_drained();

    sent_items = 0;
    batch_idx  = 0;
    while (sent_items < RANDOM_ITEMS) begin
      if (batch_idx == 4) begin
        // Receiver holds off while two full batches are offered back to back, the second stalled behind the first.
        hold_req = 1'b1;
        send_batch(sse_pkg::CAPACITY, 1'b1);
        send_batch(sse_pkg::CAPACITY, 1'b1);
      end else begin
        send_batch(pick_length(), 1'b0);
      end
      if (batch_idx == 9) begin
        wait_drained();
      end
      batch_idx++;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Receiver: stall density changes from window to window, with one long hold.
  initial begin : receiver
    int unsigned stall_pct;
    forever begin
      case ($urandom_range(3))
        0:       stall_pct = 0;
        1:       stall_pct = 20;
        2:       stall_pct = 50;
        default: stall_pct = 85;
      endcase
      repeat ($urandom_range(16, 64)) begin
        @(posedge clk);
        if (hold_req) begin
          out_stall <= 1'b1;
          repeat (LONG_HOLD) @(posedge clk);
          hold_req = 1'b0;
        end
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
